@@ src/sm3_pkg.sv @@
// ----------------------------------------------------------------------------
// SM3 package
// Constants and round helpers shared by the SM3 stream core.
// ----------------------------------------------------------------------------
`default_nettype none
package sm3_pkg;

	localparam logic [31:0] T_LOW  = 32'h79CC4519;
	localparam logic [31:0] T_HIGH = 32'h7A879D8A;

	typedef logic [31:0] word_t;

	function automatic word_t iv_word(input logic [2:0] i);
		word_t r;
		unique case (i)
			3'd0: r = 32'h7380166F;
			3'd1: r = 32'h4914B2B9;
			3'd2: r = 32'h172442D7;
			3'd3: r = 32'hDA8A0600;
			3'd4: r = 32'hA96F30BC;
			3'd5: r = 32'h163138AA;
			3'd6: r = 32'hE38DEE4D;
			default: r = 32'hB0FB0E4E;
		endcase
		return r;
	endfunction

	function automatic word_t rotl(input word_t x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic word_t perm0(input word_t x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic word_t perm1(input word_t x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} in_word_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_word_t;

endpackage
`default_nettype wire

@@ src/sm3_stream_if.sv @@
// ----------------------------------------------------------------------------
// SM3 stream interface
// Valid/ready channels: sm3_in_if carries one sm3_pkg::in_word_t, sm3_out_if one out_word_t.
// ----------------------------------------------------------------------------
`default_nettype none
interface sm3_in_if;
	logic              valid;
	logic              ready;
	sm3_pkg::in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface sm3_out_if;
	logic               valid;
	logic               ready;
	sm3_pkg::out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/sm3_hash_stream_core.sv @@
// ----------------------------------------------------------------------------
// SM3 hash stream core
// Byte-serial SM3 engine: absorbs bytes, pads, emits the 256-bit digest.
// ----------------------------------------------------------------------------
// Usage:
//  - in_ch carries one input word per handshake: a byte, a has_byte flag and
//    end_of_message. Words with has_byte low and no end are dropped.
//  - A byte is taken on its handshake in ST_IDLE. The 64th byte of a block
//    starts the compression: 64 rounds through one shared round unit
//    (message expansion runs alongside, the W window a 16-word shift line),
//    then the feed-forward XOR in ST_FIN. in_ch is not ready meanwhile.
//  - end_of_message pads byte by byte (9 to 72 padding and length bytes),
//    taking one or two compressions, then emits eight digest words on out_ch,
//    index 0 (A) first, last_word on index 7. The chaining value then returns
//    to the IV.
//  - A stalled receiver holds the output word; the core waits with it.
//  - arst_n clears control state and loads the IV; the block buffer is
//    left as is (every word is written before it is read).
// ----------------------------------------------------------------------------
`default_nettype none
module sm3_hash_stream_core (
	input  wire     clk,
	input  wire     arst_n,
	sm3_in_if.sink    in_ch,
	sm3_out_if.source out_ch
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PAD  = 6'b000010,
		ST_LEN  = 6'b000100,
		ST_RND  = 6'b001000,
		ST_FIN  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t      state_q;
	logic [31:0] cv_q [8];
	logic [31:0] wd_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [5:0]  fill_q;
	logic [63:0] len_q;
	logic [63:0] plen_q;
	logic [5:0]  rnd_q;
	logic [2:0]  oidx_q;
	logic        pad_q;   // padding in progress; return to ST_PAD after a block
	logic        fin_q;   // length written: emit digest after this block
	logic        eom_q;   // end came on a block-closing byte: pad after this block

	// byte path
	logic       do_byte;
	logic [7:0] byte_v;
	logic       fresh_in;

	assign fresh_in   = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);

	always_comb begin
		do_byte = 1'b0;
		byte_v  = 8'h00;
		unique case (state_q)
			ST_IDLE: begin
				do_byte = fresh_in && in_ch.data.has_byte;
				byte_v  = in_ch.data.data_byte;
			end
			ST_PAD: begin
				do_byte = 1'b1;
				byte_v  = pad_q ? 8'h00 : 8'h80;
			end
			ST_LEN: begin
				do_byte = 1'b1;
				byte_v  = plen_q[63:56];
			end
			default: ;
		endcase
	end

	// one shared round
	logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tj, wnew, wj, wpj;
	always_comb begin
		wj   = wd_q[0];
		wpj  = wd_q[0] ^ wd_q[4];
		wnew = sm3_pkg::perm1(wd_q[0] ^ wd_q[7] ^ sm3_pkg::rotl(wd_q[13], 5'd15))
		     ^ sm3_pkg::rotl(wd_q[3], 5'd7) ^ wd_q[10];
		tj   = (rnd_q < 6'd16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
		a12  = sm3_pkg::rotl(a_q, 5'd12);
		ss1  = sm3_pkg::rotl(a12 + e_q + sm3_pkg::rotl(tj, rnd_q[4:0]), 5'd7);
		ss2  = ss1 ^ a12;
		if (rnd_q < 6'd16) begin
			ff = a_q ^ b_q ^ c_q;
			gg = e_q ^ f_q ^ g_q;
		end else begin
			ff = (a_q & b_q) | (a_q & c_q) | (b_q & c_q);
			gg = (e_q & f_q) | (~e_q & g_q);
		end
		tt1 = ff + d_q + ss2 + wpj;
		tt2 = gg + h_q + ss1 + wj;
	end

	// block buffer / W shift line
	always_ff @(posedge clk) begin
		if (do_byte) begin
			unique case (fill_q[1:0])
				2'd0: wd_q[fill_q[5:2]] <= {byte_v, 24'h0};
				2'd1: wd_q[fill_q[5:2]][23:16] <= byte_v;
				2'd2: wd_q[fill_q[5:2]][15:8]  <= byte_v;
				default: wd_q[fill_q[5:2]][7:0] <= byte_v;
			endcase
		end else if (state_q == ST_RND) begin
			for (int k = 0; k < 15; k++) wd_q[k] <= wd_q[k+1];
			wd_q[15] <= wnew;
		end
		if (state_q == ST_RND) begin
			a_q <= tt1; b_q <= a_q; c_q <= sm3_pkg::rotl(b_q, 5'd9); d_q <= c_q;
			e_q <= sm3_pkg::perm0(tt2); f_q <= e_q;
			g_q <= sm3_pkg::rotl(f_q, 5'd19); h_q <= g_q;
		end else begin
			a_q <= cv_q[0]; b_q <= cv_q[1]; c_q <= cv_q[2]; d_q <= cv_q[3];
			e_q <= cv_q[4]; f_q <= cv_q[5]; g_q <= cv_q[6]; h_q <= cv_q[7];
		end
	end

	assign out_ch.valid            = (state_q == ST_OUT);
	assign out_ch.data.digest_word = cv_q[oidx_q];
	assign out_ch.data.word_index  = oidx_q;
	assign out_ch.data.last_word   = (oidx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int k = 0; k < 8; k++) cv_q[k] <= sm3_pkg::iv_word(3'(k));
			fill_q <= '0;
			len_q  <= '0;
			plen_q <= '0;
			rnd_q  <= '0;
			oidx_q <= '0;
			pad_q  <= 1'b0;
			fin_q  <= 1'b0;
			eom_q  <= 1'b0;
		end else begin
			if (do_byte) fill_q <= fill_q + 6'd1;
			if (state_q == ST_LEN) plen_q <= {plen_q[55:0], 8'h00};
			unique case (state_q)
				ST_IDLE: begin
					if (fresh_in) begin
						pad_q <= 1'b0;
						if (in_ch.data.has_byte) len_q <= len_q + 64'd8;
						plen_q <= len_q + (in_ch.data.has_byte ? 64'd8 : 64'd0);
						if (do_byte && fill_q == 6'd63) begin
							rnd_q   <= '0;
							fin_q   <= 1'b0;
							state_q <= ST_RND;
							eom_q   <= in_ch.data.end_of_message;
						end else if (in_ch.data.end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					pad_q <= 1'b1;
					if (fill_q == 6'd63) begin
						rnd_q <= '0; fin_q <= 1'b0; state_q <= ST_RND;
					end else if (fill_q == 6'd55) begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					if (fill_q == 6'd63) begin
						rnd_q <= '0; fin_q <= 1'b1; state_q <= ST_RND;
					end
				end
				ST_RND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_FIN;
				end
				ST_FIN: begin
					cv_q[0] <= cv_q[0] ^ a_q; cv_q[1] <= cv_q[1] ^ b_q;
					cv_q[2] <= cv_q[2] ^ c_q; cv_q[3] <= cv_q[3] ^ d_q;
					cv_q[4] <= cv_q[4] ^ e_q; cv_q[5] <= cv_q[5] ^ f_q;
					cv_q[6] <= cv_q[6] ^ g_q; cv_q[7] <= cv_q[7] ^ h_q;
					eom_q <= 1'b0;
					if (fin_q) begin
						oidx_q <= '0; state_q <= ST_OUT;
					end else if (pad_q || eom_q) begin
						state_q <= (fill_q == 6'd56) ? ST_LEN : ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_ch.ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							for (int k = 0; k < 8; k++) cv_q[k] <= sm3_pkg::iv_word(3'(k));
							fill_q  <= '0;
							len_q   <= '0;
							fin_q   <= 1'b0;
							pad_q   <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ tb/sv/sm3_hash_stream_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM3 hash stream core testbench
// Feeds byte streams with message ends through the input channel and checks
// each digest word against an in-bench SM3 predictor, under random idling.
// ----------------------------------------------------------------------------
module sm3_hash_stream_core_test;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sm3_in_if  in_ch ();
	sm3_out_if out_ch ();

	sm3_hash_stream_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [31:0] hash_state [8];
	logic [31:0] blk_words [16];
	logic [5:0]  blk_fill;
	logic [63:0] msg_bits;

	sm3_pkg::in_word_t  pending_words [$];
	sm3_pkg::out_word_t digest_queue [$];

	int  n_errors = 0;
	int  n_digests = 0;
	int  n_words_out = 0;
	int  idle_cycles = 0;
	bit  calm = 1'b0;
	int  src_gap = 0;
	int  snk_gap = 0;
	int  hold_off = 0;
	bit  hold_req = 1'b0;

	function automatic logic [31:0] rl(input logic [31:0] x, input int n);
		int k;
		k = n % 32;
		if (k == 0) begin
			return x;
		end
		return (x << k) | (x >> (32 - k));
	endfunction

	function automatic logic [31:0] p0_of(input logic [31:0] x);
		return x ^ rl(x, 9) ^ rl(x, 17);
	endfunction

	function automatic logic [31:0] p1_of(input logic [31:0] x);
		return x ^ rl(x, 15) ^ rl(x, 23);
	endfunction

	task automatic compress_block();
		logic [31:0] w [68];
		logic [31:0] wx [64];
		logic [31:0] a, b, c, d, e, f, g, h, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
		for (int j = 0; j < 16; j++) begin
			w[j] = blk_words[j];
		end
		for (int j = 16; j < 68; j++) begin
			w[j] = p1_of(w[j-16] ^ w[j-9] ^ rl(w[j-3], 15)) ^ rl(w[j-13], 7) ^ w[j-6];
		end
		for (int j = 0; j < 64; j++) begin
			wx[j] = w[j] ^ w[j+4];
		end
		a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
		e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
		for (int j = 0; j < 64; j++) begin
			tj  = (j < 16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
			a12 = rl(a, 12);
			ss1 = rl(a12 + e + rl(tj, j), 7);
			ss2 = ss1 ^ a12;
			if (j < 16) begin
				ff = a ^ b ^ c;
				gg = e ^ f ^ g;
			end else begin
				ff = (a & b) | (a & c) | (b & c);
				gg = (e & f) | (~e & g);
			end
			tt1 = ff + d + ss2 + wx[j];
			tt2 = gg + h + ss1 + w[j];
			d = c; c = rl(b, 9); b = a; a = tt1;
			h = g; g = rl(f, 19); f = e; e = p0_of(tt2);
		end
		hash_state[0] ^= a; hash_state[1] ^= b; hash_state[2] ^= c; hash_state[3] ^= d;
		hash_state[4] ^= e; hash_state[5] ^= f; hash_state[6] ^= g; hash_state[7] ^= h;
	endtask

	task automatic absorb_byte(input logic [7:0] byte_val);
		int sh;
		sh = (3 - blk_fill[1:0]) * 8;
		if (blk_fill[1:0] == 2'd0) begin
			blk_words[blk_fill[5:2]] = 32'(byte_val) << sh;
		end else begin
			blk_words[blk_fill[5:2]] |= 32'(byte_val) << sh;
		end
		blk_fill = blk_fill + 6'd1;
		if (blk_fill == 6'd0) begin
			compress_block();
		end
	endtask

	function automatic logic [31:0] iv_word_of(input int i);
		logic [31:0] ivs [8] = '{32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
			32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};
		return ivs[i];
	endfunction

	task automatic reset_hash();
		for (int i = 0; i < 8; i++) begin
			hash_state[i] = iv_word_of(i);
		end
		blk_fill = '0;
		msg_bits = '0;
	endtask

	// Work out the digest words an accepted input word causes.
	task automatic predict_digest(input sm3_pkg::in_word_t iw);
		logic [63:0] len;
		sm3_pkg::out_word_t ow;
		if (iw.has_byte) begin
			msg_bits = msg_bits + 64'd8;
			absorb_byte(iw.data_byte);
		end
		if (!iw.end_of_message) begin
			return;
		end
		len = msg_bits;
		absorb_byte(8'h80);
		while (blk_fill != 6'd56) begin
			absorb_byte(8'h00);
		end
		for (int i = 0; i < 8; i++) begin
			absorb_byte(len[8*(7-i) +: 8]);
		end
		for (int i = 0; i < 8; i++) begin
			ow.digest_word = hash_state[i];
			ow.word_index  = 3'(i);
			ow.last_word   = (i == 7);
			digest_queue.push_back(ow);
		end
		reset_hash();
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
		n_errors++;
	endtask

	// message of n random bytes, optionally closed with a bare end word
	task automatic add_message(input int n, input bit bare_end);
		sm3_pkg::in_word_t iw;
		for (int i = 0; i < n; i++) begin
			iw.data_byte = 8'($urandom);
			iw.has_byte = 1'b1;
			iw.end_of_message = (i == n - 1) && !bare_end;
			pending_words.push_back(iw);
			if ($urandom_range(0, 15) == 0) begin
				iw.has_byte = 1'b0;
				iw.end_of_message = 1'b0;
				iw.data_byte = 8'($urandom);
				pending_words.push_back(iw);
			end
		end
		if (bare_end || n == 0) begin
			iw.data_byte = 8'($urandom);
			iw.has_byte = 1'b0;
			iw.end_of_message = 1'b1;
			pending_words.push_back(iw);
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data  <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict_digest(in_ch.data);
			end
			if (in_ch.valid && !in_ch.ready) begin
				// hold the word on offer
			end else if (src_gap > 0) begin
				src_gap <= src_gap - 1;
				in_ch.valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				if (!calm && $urandom_range(0, 9) == 0) begin
					src_gap <= $urandom_range(1, 11);
					in_ch.valid <= 1'b0;
				end else begin
					in_ch.valid <= 1'b1;
					in_ch.data  <= pending_words.pop_front();
				end
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// monitor and receiver
	always @(posedge clk) begin
		sm3_pkg::out_word_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				n_words_out++;
				if (digest_queue.size() == 0) begin
					report_mismatch("unexpected digest word", out_ch.data.digest_word, 32'd0);
				end else begin
					want = digest_queue.pop_front();
					if (out_ch.data.digest_word !== want.digest_word)
						report_mismatch("digest_word", out_ch.data.digest_word,
							want.digest_word);
					if (out_ch.data.word_index !== want.word_index)
						report_mismatch("word_index", 32'(out_ch.data.word_index),
							32'(want.word_index));
					if (out_ch.data.last_word !== want.last_word)
						report_mismatch("last_word", 32'(out_ch.data.last_word),
							32'(want.last_word));
					if (want.last_word) begin
						n_digests++;
					end
				end
			end
			if (hold_req && hold_off == 0) begin
				hold_off <= 600;
				out_ch.ready <= 1'b0;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ch.ready <= (hold_off == 1);
			end else if (snk_gap > 0) begin
				snk_gap <= snk_gap - 1;
				out_ch.ready <= (snk_gap == 1);
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				snk_gap <= $urandom_range(1, 11);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog: cycles with no handshake on either channel
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no progress, %0d words still due", digest_queue.size());
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		sm3_pkg::in_word_t iw;
		reset_hash();
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty message, no-op words, "abc", block edges, padding overflow
		add_message(0, 1'b1);
		iw = '{data_byte: 8'hFF, has_byte: 1'b0, end_of_message: 1'b0};
		pending_words.push_back(iw);
		iw = '{data_byte: 8'h61, has_byte: 1'b1, end_of_message: 1'b0};
		pending_words.push_back(iw);
		iw.data_byte = 8'h62;
		pending_words.push_back(iw);
		iw = '{data_byte: 8'h63, has_byte: 1'b1, end_of_message: 1'b1};
		pending_words.push_back(iw);
		iw = '{data_byte: 8'h00, has_byte: 1'b1, end_of_message: 1'b1};
		pending_words.push_back(iw);
		iw = '{data_byte: 8'hFF, has_byte: 1'b1, end_of_message: 1'b1};
		pending_words.push_back(iw);
		add_message(55, 1'b0);
		add_message(56, 1'b0);
		add_message(64, 1'b0);

		// hold the receiver off while a batch of messages queues up
		hold_req = 1'b1;
		for (int m = 0; m < 6; m++) begin
			add_message($urandom_range(1, 4), 1'b0);
		end
		wait (pending_words.size() == 0);
		hold_req = 1'b0;

		// random short messages, some closed by a bare end word
		for (int m = 0; m < 10; m++) begin
			if (m == 7) begin
				wait (pending_words.size() == 0);
				calm = 1'b1;
			end
			add_message($urandom_range(0, 4), $urandom_range(0, 3) == 0);
		end

		wait (pending_words.size() == 0 && !in_ch.valid);
		wait (digest_queue.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d digests (%0d words): empty, block-edge, padding overflow,",
			n_digests, n_words_out);
		$display("bare-end and random messages, with idling and a long output stall.");
		if (n_errors == 0 && digest_queue.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
